// ===== rtl/dsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Disjoint-set union package
// Shared widths, operation codes and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int NODES   = 1024;
  localparam int NODE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int STEP_W  = $clog2(NODES + 1);

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(2 * NODES - 1);
  localparam logic [STEP_W-1:0]  STEP_LIMIT  = STEP_W'(NODES);

  typedef enum logic [1:0] {
    FUNC_MAKE  = 2'd0,
    FUNC_FIND  = 2'd1,
    FUNC_UNION = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_NODE,
    FIN_CUR,
    FIN_RA,
    FIN_LINK
  } fin_e;

  typedef struct packed {
    logic load;
    logic make_wr;
    logic walk_init;
    logic walk_step;
    logic comp_init;
    logic comp_step;
    logic sel_b;
    logic save_ra;
    logic cnt_sel_b;
    logic lat_cnt_a;
    logic link;
    fin_e fin;
  } cmd_t;

  typedef struct packed {
    logic is_make;
    logic is_find;
    logic is_union;
    logic a_ok;
    logic b_ok;
    logic walk_done;
    logic comp_go;
    logic comp_more;
    logic same_root;
  } status_t;

  function automatic logic in_range(logic [NODE_W-1:0] n);
    return {1'b0, n} < (NODE_W + 1)'(NODES);
  endfunction

endpackage

// ===== rtl/disjoint_set_union_top.sv =====
// ----------------------------------------------------------------------------
// Disjoint-set union top level
// Union-find table by set size with path compression over 1024 nodes.
// ----------------------------------------------------------------------------
// Usage:
//   Drive func_i, node_a_i and node_b_i and raise start; the transaction is
//   taken at the clock edge where start is high and busy is low. busy stays
//   high while the operation runs. The result appears on result_root_o and
//   joined_o for exactly one cycle, marked by done_o, and busy is already low
//   in that cycle, so the next transaction may be taken there.
// Operation steps:
//   make or ignored operation: finishes at dispatch
//   find: root walk from node_a, then path compression
//   union: as find for node_a, then node_b; size read and link if roots differ
//   Each link costs one read of the parent table for the root walk and one
//   read/write pair for path compression; union by size keeps the number of
//   links from a node to its root near log2 of the set size.
// Reset: clears the controller; the tables are not cleared, and every node
//   must be made before it is looked up or joined.
// The receiver cannot stall: done_o is a single-cycle strobe.
// ----------------------------------------------------------------------------
module disjoint_set_union_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 func_i,
  input  logic [dsu_pkg::NODE_W-1:0] node_a_i,
  input  logic [dsu_pkg::NODE_W-1:0] node_b_i,
  output logic                       done_o,
  output logic [dsu_pkg::NODE_W-1:0] result_root_o,
  output logic                       joined_o
);

  dsu_pkg::cmd_t    cmd;
  dsu_pkg::status_t st;

  dsu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  dsu_dpath u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .func_i        (func_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .result_root_o (result_root_o),
    .joined_o      (joined_o)
  );

endmodule

// ===== rtl/dsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Disjoint-set union controller
// Sequences make, root walks, path compression and the union link step.
// ----------------------------------------------------------------------------
module dsu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  input  dsu_pkg::status_t st_i,
  output dsu_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_WALK,
    S_CINIT,
    S_CSTEP,
    S_NEXT,
    S_URB,
    S_ULINK
  } state_e;

  state_e state_q, state_d;
  logic   side_q, side_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.fin = dsu_pkg::FIN_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          side_d     = 1'b0;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (st_i.is_make) begin
          cmd_o.make_wr = st_i.a_ok;
          cmd_o.fin     = dsu_pkg::FIN_NODE;
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end else if ((st_i.is_find && st_i.a_ok) ||
                     (st_i.is_union && st_i.a_ok && st_i.b_ok)) begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_WALK;
        end else begin
          cmd_o.fin = dsu_pkg::FIN_NODE;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (st_i.walk_done) begin
          state_d = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd_o.comp_init = 1'b1;
        cmd_o.sel_b     = side_q;
        state_d         = st_i.comp_go ? S_CSTEP : S_NEXT;
      end
      S_CSTEP: begin
        cmd_o.comp_step = 1'b1;
        if (!st_i.comp_more) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (st_i.is_find) begin
          cmd_o.fin = dsu_pkg::FIN_CUR;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else if (!side_q) begin
          cmd_o.save_ra   = 1'b1;
          cmd_o.walk_init = 1'b1;
          cmd_o.sel_b     = 1'b1;
          side_d          = 1'b1;
          state_d         = S_WALK;
        end else if (st_i.same_root) begin
          cmd_o.fin = dsu_pkg::FIN_RA;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_URB;
        end
      end
      S_URB: begin
        cmd_o.lat_cnt_a = 1'b1;
        cmd_o.cnt_sel_b = 1'b1;
        state_d         = S_ULINK;
      end
      S_ULINK: begin
        cmd_o.link = 1'b1;
        cmd_o.fin  = dsu_pkg::FIN_LINK;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      side_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/dsu_dpath.sv =====
// ----------------------------------------------------------------------------
// Disjoint-set union datapath
// Parent and count tables, walk registers, link arithmetic and result registers.
// ----------------------------------------------------------------------------
module dsu_dpath (
  input  logic                       clk_i,
  input  dsu_pkg::cmd_t              cmd_i,
  output dsu_pkg::status_t           st_o,
  input  logic [1:0]                 func_i,
  input  logic [dsu_pkg::NODE_W-1:0] node_a_i,
  input  logic [dsu_pkg::NODE_W-1:0] node_b_i,
  output logic [dsu_pkg::NODE_W-1:0] result_root_o,
  output logic                       joined_o
);

  logic [dsu_pkg::NODE_W-1:0]  parent_mem [dsu_pkg::NODES];
  logic [dsu_pkg::COUNT_W-1:0] count_mem  [dsu_pkg::NODES];

  logic [1:0]                  func_q;
  logic [dsu_pkg::NODE_W-1:0]  a_q, b_q, cur_q, walk_q, ra_q;
  logic [dsu_pkg::STEP_W-1:0]  steps_q, k_q;
  logic [dsu_pkg::NODE_W-1:0]  par_rdata_q;
  logic [dsu_pkg::COUNT_W-1:0] cnt_rdata_q, cnt_a_q;
  logic [dsu_pkg::NODE_W-1:0]  root_q;
  logic                        joined_q;

  logic [dsu_pkg::NODE_W-1:0]  origin, next, par_raddr, par_waddr, par_wdata;
  logic [dsu_pkg::NODE_W-1:0]  cnt_raddr, cnt_waddr, big, small_root;
  logic [dsu_pkg::COUNT_W-1:0] cnt_wdata, sum_sat;
  logic [dsu_pkg::COUNT_W:0]   sum;
  logic                        par_we, cnt_we, term, next_ok;

  assign origin  = cmd_i.sel_b ? b_q : a_q;
  assign next    = par_rdata_q;
  assign next_ok = dsu_pkg::in_range(next);
  assign term    = !next_ok || (next == cur_q);

  assign par_raddr = (cmd_i.walk_init || cmd_i.comp_init) ? origin : next;
  assign cnt_raddr = cmd_i.cnt_sel_b ? cur_q : ra_q;

  always_comb begin
    if (cnt_a_q < cnt_rdata_q) begin
      big        = cur_q;
      small_root = ra_q;
    end else begin
      big        = ra_q;
      small_root = cur_q;
    end
  end

  assign sum     = {1'b0, cnt_a_q} + {1'b0, cnt_rdata_q};
  assign sum_sat = (sum > {1'b0, dsu_pkg::COUNT_LIMIT}) ? dsu_pkg::COUNT_LIMIT
                                                        : sum[dsu_pkg::COUNT_W-1:0];

  always_comb begin
    par_we    = 1'b0;
    par_waddr = a_q;
    par_wdata = a_q;
    cnt_we    = 1'b0;
    cnt_waddr = a_q;
    cnt_wdata = dsu_pkg::COUNT_W'(1);
    if (cmd_i.make_wr) begin
      par_we = 1'b1;
      cnt_we = 1'b1;
    end else if (cmd_i.comp_step) begin
      par_we    = 1'b1;
      par_waddr = walk_q;
      par_wdata = cur_q;
    end else if (cmd_i.link) begin
      par_we    = 1'b1;
      par_waddr = small_root;
      par_wdata = big;
      cnt_we    = 1'b1;
      cnt_waddr = big;
      cnt_wdata = sum_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    par_rdata_q <= parent_mem[par_raddr];
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_rdata_q <= count_mem[cnt_raddr];
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
    end
    if (cmd_i.walk_init) begin
      cur_q   <= origin;
      steps_q <= '0;
    end else if (cmd_i.walk_step && !term) begin
      cur_q   <= next;
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.comp_init) begin
      walk_q <= origin;
      k_q    <= '0;
    end else if (cmd_i.comp_step && next_ok) begin
      walk_q <= next;
      k_q    <= k_q + 1'b1;
    end
    if (cmd_i.save_ra) begin
      ra_q <= cur_q;
    end
    if (cmd_i.lat_cnt_a) begin
      cnt_a_q <= cnt_rdata_q;
    end
    case (cmd_i.fin)
      dsu_pkg::FIN_NODE: begin
        root_q   <= a_q;
        joined_q <= 1'b0;
      end
      dsu_pkg::FIN_CUR: begin
        root_q   <= cur_q;
        joined_q <= 1'b0;
      end
      dsu_pkg::FIN_RA: begin
        root_q   <= ra_q;
        joined_q <= 1'b0;
      end
      dsu_pkg::FIN_LINK: begin
        root_q   <= big;
        joined_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign st_o.is_make   = (func_q == dsu_pkg::FUNC_MAKE);
  assign st_o.is_find   = (func_q == dsu_pkg::FUNC_FIND);
  assign st_o.is_union  = (func_q == dsu_pkg::FUNC_UNION);
  assign st_o.a_ok      = dsu_pkg::in_range(a_q);
  assign st_o.b_ok      = dsu_pkg::in_range(b_q);
  assign st_o.walk_done = term || ((steps_q + 1'b1) == dsu_pkg::STEP_LIMIT);
  assign st_o.comp_go   = (steps_q != '0) && (origin != cur_q);
  assign st_o.comp_more = next_ok && ((k_q + 1'b1) < steps_q) && (next != cur_q);
  assign st_o.same_root = (ra_q == cur_q);

  assign result_root_o = root_q;
  assign joined_o      = joined_q;

endmodule

// ===== rtl/dsu_chk.sv =====
// ----------------------------------------------------------------------------
// Disjoint-set union port checker
// Timing relations between start, busy and the done strobe.
// ----------------------------------------------------------------------------
module dsu_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_no_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("done in the cycle after acceptance");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done held for more than one cycle");

  a_busy_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

endmodule

bind disjoint_set_union_top dsu_chk u_dsu_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Disjoint-set union testbench
// Drives make, find, union and unused-code transactions into the union-find
// table and checks every result strobe against a predictor kept in step with
// the accepted transactions. Directed checks cover the extreme node indices,
// tie breaks, unions within one set, path compression and remaking a node.
// Random sequences, mostly on nodes in a sliding window, run first with
// a sender that idles often, then very often, then never.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         WATCHDOG_MAX = 20000;
  localparam int         SETTLE_CYC   = 64;
  localparam int         WINDOW       = 48;

  typedef struct {
    logic [dsu_pkg::NODE_W-1:0] root;
    logic                       joined;
  } root_rec_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [1:0]                 func_i;
  logic [dsu_pkg::NODE_W-1:0] node_a_i;
  logic [dsu_pkg::NODE_W-1:0] node_b_i;
  logic                       done_o;
  logic [dsu_pkg::NODE_W-1:0] result_root_o;
  logic                       joined_o;

  logic [dsu_pkg::NODE_W-1:0]  parent_tbl [dsu_pkg::NODES];
  logic [dsu_pkg::COUNT_W-1:0] size_tbl   [dsu_pkg::NODES];
  bit                          made_map   [dsu_pkg::NODES];
  int                          made_list  [$];
  root_rec_t                   pending_roots [$];
  root_rec_t                   got_rec;
  int                          err_count;
  int                          idle_pct;
  int                          stall_cnt;

  disjoint_set_union_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .done_o        (done_o),
    .result_root_o (result_root_o),
    .joined_o      (joined_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  function automatic int chase_root(input int node);
    int cur;
    int steps;
    int nxt;
    int walk;
    int k;
    cur   = node;
    steps = 0;
    while (steps < dsu_pkg::NODES) begin
      nxt = parent_tbl[cur];
      if (nxt >= dsu_pkg::NODES || nxt == cur) break;
      cur = nxt;
      steps++;
    end
    walk = node;
    k    = 0;
    while (k < steps && walk != cur) begin
      nxt = parent_tbl[walk];
      parent_tbl[walk] = dsu_pkg::NODE_W'(cur);
      if (nxt >= dsu_pkg::NODES) break;
      walk = nxt;
      k++;
    end
    return cur;
  endfunction

  function automatic root_rec_t predict_root(input logic [1:0] f, input int a, input int b);
    root_rec_t rec;
    int        ra;
    int        rb;
    int        big;
    int        lesser;
    int        sum;
    rec.root   = dsu_pkg::NODE_W'(a);
    rec.joined = 1'b0;
    case (f)
      dsu_pkg::FUNC_MAKE: begin
        if (a < dsu_pkg::NODES) begin
          parent_tbl[a] = dsu_pkg::NODE_W'(a);
          size_tbl[a]   = dsu_pkg::COUNT_W'(1);
        end
      end
      dsu_pkg::FUNC_FIND: begin
        if (a < dsu_pkg::NODES) rec.root = dsu_pkg::NODE_W'(chase_root(a));
      end
      dsu_pkg::FUNC_UNION: begin
        if (a < dsu_pkg::NODES && b < dsu_pkg::NODES) begin
          ra = chase_root(a);
          rb = chase_root(b);
          rec.root = dsu_pkg::NODE_W'(ra);
          if (ra != rb) begin
            big    = ra;
            lesser = rb;
            if (size_tbl[ra] < size_tbl[rb]) begin
              big    = rb;
              lesser = ra;
            end
            parent_tbl[lesser] = dsu_pkg::NODE_W'(big);
            sum = int'(size_tbl[big]) + int'(size_tbl[lesser]);
            size_tbl[big] = (sum > int'(dsu_pkg::COUNT_LIMIT)) ? dsu_pkg::COUNT_LIMIT
                                                              : dsu_pkg::COUNT_W'(sum);
            rec.root   = dsu_pkg::NODE_W'(big);
            rec.joined = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return rec;
  endfunction

  task automatic send_item(input logic [1:0] f, input int a, input int b);
    root_rec_t rec;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start    = 1'b1;
    func_i   = f;
    node_a_i = dsu_pkg::NODE_W'(a);
    node_b_i = dsu_pkg::NODE_W'(b);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    rec = predict_root(f, a, b);
    pending_roots.insert(pending_roots.size(), rec);
    if (f == dsu_pkg::FUNC_MAKE && !made_map[a]) begin
      made_map[a] = 1'b1;
      made_list.insert(made_list.size(), a);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (pending_roots.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("result without transaction, root", result_root_o, 0);
      end else begin
        got_rec = pending_roots.pop_front();
        if (result_root_o !== got_rec.root)
          report_mismatch("result_root", result_root_o, got_rec.root);
        if (joined_o !== got_rec.joined)
          report_mismatch("joined", joined_o, got_rec.joined);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_MAX) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic test_make_find();
    send_item(dsu_pkg::FUNC_MAKE, 0, 1023);
    send_item(dsu_pkg::FUNC_MAKE, 1023, 0);
    send_item(dsu_pkg::FUNC_FIND, 0, 1023);
    send_item(dsu_pkg::FUNC_FIND, 1023, 0);
    wait_drain();
  endtask

  task automatic test_union_ties();
    send_item(dsu_pkg::FUNC_UNION, 0, 1023);
    send_item(dsu_pkg::FUNC_UNION, 1023, 0);
    send_item(dsu_pkg::FUNC_FIND, 1023, 682);
    send_item(dsu_pkg::FUNC_MAKE, 5, 341);
    send_item(dsu_pkg::FUNC_UNION, 5, 0);
    wait_drain();
  endtask

  task automatic test_path_compression();
    for (int n = 8; n < 12; n++) send_item(dsu_pkg::FUNC_MAKE, n, 0);
    send_item(dsu_pkg::FUNC_UNION, 8, 9);
    send_item(dsu_pkg::FUNC_UNION, 10, 11);
    send_item(dsu_pkg::FUNC_UNION, 8, 10);
    send_item(dsu_pkg::FUNC_FIND, 11, 0);
    send_item(dsu_pkg::FUNC_FIND, 11, 0);
    send_item(dsu_pkg::FUNC_MAKE, 10, 0);
    send_item(dsu_pkg::FUNC_FIND, 11, 0);
    wait_drain();
  endtask

  task automatic test_unused_code();
    send_item(FUNC_UNUSED, 682, 341);
    send_item(FUNC_UNUSED, 341, 682);
    wait_drain();
  endtask

  function automatic int pick_node(input int base);
    if ($urandom_range(0, 9) == 0 && made_list.size() > 0)
      return made_list[$urandom_range(0, made_list.size() - 1)];
    return (base + $urandom_range(0, WINDOW - 1)) % dsu_pkg::NODES;
  endfunction

  task automatic test_random(input int count, input int pct);
    int base;
    int sel;
    int a;
    int b;
    idle_pct = pct;
    base = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) base = $urandom_range(0, dsu_pkg::NODES - 1);
      sel = $urandom_range(0, 99);
      a = pick_node(base);
      b = pick_node(base);
      if (sel < 15) begin
        if ($urandom_range(0, 99) < 30) a = $urandom_range(0, dsu_pkg::NODES - 1);
        send_item(dsu_pkg::FUNC_MAKE, a, $urandom_range(0, dsu_pkg::NODES - 1));
      end else if (sel < 95 - 5) begin
        if (!made_map[a]) begin
          send_item(dsu_pkg::FUNC_MAKE, a, $urandom_range(0, dsu_pkg::NODES - 1));
        end else if (sel < 50) begin
          send_item(dsu_pkg::FUNC_FIND, a, $urandom_range(0, dsu_pkg::NODES - 1));
        end else if (!made_map[b]) begin
          send_item(dsu_pkg::FUNC_MAKE, b, $urandom_range(0, dsu_pkg::NODES - 1));
        end else begin
          send_item(dsu_pkg::FUNC_UNION, a, b);
        end
      end else begin
        send_item(FUNC_UNUSED, $urandom_range(0, dsu_pkg::NODES - 1),
                  $urandom_range(0, dsu_pkg::NODES - 1));
      end
    end
    wait_drain();
  endtask

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    func_i    = dsu_pkg::FUNC_MAKE;
    node_a_i  = '0;
    node_b_i  = '0;
    err_count = 0;
    idle_pct  = 31;
    for (int n = 0; n < dsu_pkg::NODES; n++) begin
      parent_tbl[n] = '0;
      size_tbl[n]   = '0;
      made_map[n]   = 1'b0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_make_find();
    test_union_ties();
    test_path_compression();
    test_unused_code();
    test_random(630, 31);
    test_random(630, 87);
    test_random(640, 0);

    repeat (SETTLE_CYC) @(negedge clk_i);
    if (pending_roots.size() != 0)
      report_mismatch("results still outstanding", 0, pending_roots.size());
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
